// ===== rtl/core/gng_pkg.sv =====
// ----------------------------------------------------------------------------
// gng_pkg
// Shared types and constants of the Gaussian noise generator.
// ----------------------------------------------------------------------------
package gng_pkg;

    localparam logic [63:0] XS_MULT    = 64'd2685821657736338717;
    localparam logic [31:0] LN2_Q32    = 32'd2977044471;
    localparam logic [31:0] HALFPI_Q30 = 32'd1686629713;
    localparam logic [30:0] ONE_Q30    = 31'd1073741824;
    localparam logic [63:0] BASE_SEED_RST = 64'd1;
    localparam logic [63:0] WORK_SEED_RST = 64'd2;
    localparam logic [15:0] SCALE_RST  = 16'd4096;

    localparam logic CFG_SEED  = 1'b0;
    localparam logic CFG_SCALE = 1'b1;

    typedef struct packed {
        logic first;
        logic last;
    } in_t;

    typedef struct packed {
        logic signed [20:0] sample;
        logic               final_res;
    } out_t;

    // one drawn pair, queued between front and back
    typedef struct packed {
        logic [63:0] r1;
        logic [31:0] p;
        logic [15:0] scale;
        logic        last;
        logic        zero;
    } entry_t;

    // divisor 2k(2k+1) of the sine series, round 0 is k = 8
    function automatic logic [8:0] sin_div(input logic [2:0] idx);
        logic [8:0] d;
        unique case (idx)
            3'd0: d = 9'd272;
            3'd1: d = 9'd210;
            3'd2: d = 9'd156;
            3'd3: d = 9'd110;
            3'd4: d = 9'd72;
            3'd5: d = 9'd42;
            3'd6: d = 9'd20;
            default: d = 9'd6;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor)
    function automatic logic [31:0] sin_recip(input logic [2:0] idx);
        logic [31:0] m;
        unique case (idx)
            3'd0: m = 32'd15790320;
            3'd1: m = 32'd20452225;
            3'd2: m = 32'd27531841;
            3'd3: m = 32'd39045157;
            3'd4: m = 32'd59652323;
            3'd5: m = 32'd102261126;
            3'd6: m = 32'd214748364;
            default: m = 32'd715827882;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/core/gaussian_noise_generator_top.sv =====
// ----------------------------------------------------------------------------
// gaussian_noise_generator_top
// Box-Muller Gaussian noise from a xorshift64* source, Q12 output.
// ----------------------------------------------------------------------------
// Each request beat yields one sample beat. The front draws two generator
// outputs, plus a base seed step after a last beat; the back works on one
// sample at a time, bound by its single shared 32x32 multiplier and the
// 24-round log and 28-step square root. A two-entry queue lets the front
// draw ahead, and the output register holds a finished sample while the
// next one is computed, so the back sets the sustained rate. No clearing
// pass after reset.
module gaussian_noise_generator_top (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  gng_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output gng_pkg::out_t  m_data,
    input  logic           cfg_wr_en,
    input  logic           cfg_idx,
    input  logic [63:0]    cfg_data
);

    logic            push;
    logic            pop;
    logic            q_full;
    logic            rd_valid;
    gng_pkg::entry_t push_data;
    gng_pkg::entry_t rd_data;

    gng_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    gng_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .rd_valid  (rd_valid),
        .rd_data   (rd_data)
    );

    gng_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_valid (rd_valid),
        .rd_data  (rd_data),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ===== rtl/core/gng_front.sv =====
// ----------------------------------------------------------------------------
// gng_front
// Takes requests, owns both seeds and the registers, draws two xorshift64*
// outputs per request unless the scale is zero, on one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module gng_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  gng_pkg::in_t          s_data,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_idx,
    input  logic [63:0]           cfg_data,
    output logic                  push,
    output gng_pkg::entry_t       push_data,
    input  logic                  q_full
);

    typedef enum logic [2:0] {F_IDLE, F_MIX, F_MUL0, F_MUL1, F_MUL2, F_PUSH} fstate_t;
    typedef enum logic [1:0] {P_R1, P_R2, P_BASE} phase_t;

    fstate_t     state_reg;
    phase_t      phase_reg;
    logic [63:0] base_seed_reg;
    logic [63:0] work_seed_reg;
    logic [63:0] x_reg;
    logic [63:0] acc_reg;
    logic [63:0] r1_reg;
    logic [31:0] p_reg;
    logic [15:0] scale_reg;
    logic [15:0] item_scale_reg;
    logic        last_reg;
    logic        zero_reg;

    logic [63:0] src;
    logic [63:0] mix_a;
    logic [63:0] mix_b;
    logic [63:0] mix;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [63:0] step_res;

    always_comb begin
        src   = (phase_reg == P_BASE) ? base_seed_reg : work_seed_reg;
        mix_a = src ^ (src >> 12);
        mix_b = mix_a ^ (mix_a << 25);
        mix   = mix_b ^ (mix_b >> 27);
    end

    always_comb begin
        unique case (state_reg)
            F_MUL1: begin
                mul_a = x_reg[31:0];
                mul_b = gng_pkg::XS_MULT[63:32];
            end
            F_MUL2: begin
                mul_a = x_reg[63:32];
                mul_b = gng_pkg::XS_MULT[31:0];
            end
            default: begin
                mul_a = x_reg[31:0];
                mul_b = gng_pkg::XS_MULT[31:0];
            end
        endcase
        prod     = 64'(mul_a) * 64'(mul_b);
        step_res = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
    end

    assign s_ready   = (state_reg == F_IDLE);
    assign push      = (state_reg == F_PUSH) && !q_full;
    assign push_data = '{r1: r1_reg, p: p_reg, scale: item_scale_reg,
                         last: last_reg, zero: zero_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= F_IDLE;
            phase_reg     <= P_R1;
            base_seed_reg <= gng_pkg::BASE_SEED_RST;
            work_seed_reg <= gng_pkg::WORK_SEED_RST;
            scale_reg     <= gng_pkg::SCALE_RST;
        end else begin
            unique case (state_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        last_reg       <= s_data.last;
                        item_scale_reg <= scale_reg;
                        phase_reg      <= P_R1;
                        if (scale_reg == 16'd0) begin
                            zero_reg  <= 1'b1;
                            state_reg <= F_PUSH;
                        end else begin
                            zero_reg <= 1'b0;
                            if (s_data.first) begin
                                work_seed_reg <= base_seed_reg + 64'd1;
                            end
                            state_reg <= F_MIX;
                        end
                    end
                end
                F_MIX: begin
                    x_reg     <= mix;
                    state_reg <= F_MUL0;
                end
                F_MUL0: begin
                    acc_reg   <= prod;
                    state_reg <= F_MUL1;
                end
                F_MUL1: begin
                    acc_reg   <= step_res;
                    state_reg <= F_MUL2;
                end
                F_MUL2: begin
                    unique case (phase_reg)
                        P_R1: begin
                            work_seed_reg <= step_res;
                            r1_reg        <= step_res;
                            phase_reg     <= P_R2;
                            state_reg     <= F_MIX;
                        end
                        P_R2: begin
                            work_seed_reg <= step_res;
                            p_reg         <= step_res[63:32];
                            state_reg     <= F_PUSH;
                        end
                        default: begin
                            base_seed_reg <= step_res;
                            state_reg     <= F_IDLE;
                        end
                    endcase
                end
                default: begin
                    // hold until the queue has room
                    if (!q_full) begin
                        if (last_reg && !zero_reg) begin
                            phase_reg <= P_BASE;
                            state_reg <= F_MIX;
                        end else begin
                            state_reg <= F_IDLE;
                        end
                    end
                end
            endcase
            if (cfg_wr_en) begin
                unique case (cfg_idx)
                    gng_pkg::CFG_SEED:  base_seed_reg <= cfg_data;
                    default:            scale_reg     <= cfg_data[15:0];
                endcase
            end
        end
    end

endmodule

// ===== rtl/core/gng_queue.sv =====
// ----------------------------------------------------------------------------
// gng_queue
// Two-entry queue of drawn pairs between the front and the back.
// ----------------------------------------------------------------------------
module gng_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  gng_pkg::entry_t push_data,
    output logic            full,
    input  logic            pop,
    output logic            rd_valid,
    output gng_pkg::entry_t rd_data
);

    gng_pkg::entry_t mem_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

// ===== rtl/core/gng_back.sv =====
// ----------------------------------------------------------------------------
// gng_back
// Turns a drawn pair into one sample: log, square root, sine and scaling;
// log, sine and scaling share one 32x32 multiplier; ends in the output register.
// ----------------------------------------------------------------------------
module gng_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            rd_valid,
    input  gng_pkg::entry_t rd_data,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output gng_pkg::out_t   m_data
);

    typedef enum logic [3:0] {
        B_IDLE, B_NORM, B_LOG, B_LN, B_SQRT, B_ANG, B_Z2,
        B_S1, B_S2, B_S3, B_SN, B_RT, B_SC, B_OUT
    } bstate_t;

    bstate_t       state_reg;
    logic [63:0]   r_reg;
    logic [5:0]    lz_reg;
    logic [2:0]    step_reg;
    logic [4:0]    cnt_reg;
    logic [31:0]   m_reg;
    logic [23:0]   frac_reg;
    logic [55:0]   rad_reg;
    logic [57:0]   res_reg;
    logic [55:0]   bit_reg;
    logic [31:0]   p_reg;
    logic [15:0]   scale_reg;
    logic          last_reg;
    logic          zero_reg;
    logic [30:0]   z_reg;
    logic [31:0]   z2_reg;
    logic [30:0]   h_reg;
    logic [31:0]   x_reg;
    logic [29:0]   q0_reg;
    logic [30:0]   sn_reg;
    logic [28:0]   a_reg;
    logic [20:0]   sample_reg;
    logic          m_valid_reg;
    gng_pkg::out_t m_data_reg;

    logic [31:0]   mul_a;
    logic [31:0]   mul_b;
    logic [63:0]   prod;
    logic [6:0]    sh;
    logic [63:0]   top;
    logic [30:0]   t;
    logic [57:0]   trial;
    logic [31:0]   q_raw;
    logic [31:0]   q;
    logic [8:0]    div;
    logic [31:0]   qd;
    logic [31:0]   rem;
    logic [30:0]   quot;
    logic [39:0]   mag;
    logic [20:0]   mag_sat;

    always_comb begin
        sh    = 7'd32 >> step_reg;
        top   = r_reg >> (7'd64 - sh);
        t     = (31'(lz_reg) + 31'd1) << 24;
        t     = t - 31'(frac_reg);
        trial = res_reg + 58'(bit_reg);
        q_raw = {1'b0, p_reg[30:0]};
        q     = (q_raw > 32'h4000_0000) ? (32'h8000_0000 - q_raw) : q_raw;
        div   = gng_pkg::sin_div(cnt_reg[2:0]);
        qd    = 32'(q0_reg) * 32'(div);
        rem   = x_reg - qd;
        quot  = (rem >= 32'(div)) ? 31'(q0_reg) + 31'd1 : 31'(q0_reg);
    end

    always_comb begin
        unique case (state_reg)
            B_LOG: begin mul_a = m_reg;            mul_b = m_reg;               end
            B_LN:  begin mul_a = 32'(t);           mul_b = gng_pkg::LN2_Q32;    end
            B_ANG: begin mul_a = q;                mul_b = gng_pkg::HALFPI_Q30; end
            B_Z2:  begin mul_a = 32'(z_reg);       mul_b = 32'(z_reg);          end
            B_S1:  begin mul_a = z2_reg;           mul_b = 32'(h_reg);          end
            B_S2:  begin mul_a = x_reg;
                         mul_b = gng_pkg::sin_recip(cnt_reg[2:0]);              end
            B_SN:  begin mul_a = 32'(z_reg);       mul_b = 32'(h_reg);          end
            B_RT:  begin mul_a = 32'(sn_reg);      mul_b = 32'(res_reg[28:0]);  end
            B_SC:  begin mul_a = 32'(a_reg);       mul_b = 32'(scale_reg);      end
            default: begin mul_a = '0;             mul_b = '0;                  end
        endcase
        prod = 64'(mul_a) * 64'(mul_b);
        mag  = prod[63:24];
        if (p_reg[31]) begin
            mag_sat = (mag > 40'd1048576) ? 21'h10_0000 : 21'(mag);
        end else begin
            mag_sat = (mag > 40'd1048575) ? 21'h0F_FFFF : 21'(mag);
        end
    end

    assign pop     = (state_reg == B_IDLE) && rd_valid;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready && state_reg != B_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE: begin
                    if (rd_valid) begin
                        r_reg      <= (rd_data.r1 == 64'd0) ? 64'd1 : rd_data.r1;
                        p_reg      <= rd_data.p;
                        scale_reg  <= rd_data.scale;
                        last_reg   <= rd_data.last;
                        zero_reg   <= rd_data.zero;
                        lz_reg     <= '0;
                        step_reg   <= '0;
                        sample_reg <= '0;
                        state_reg  <= rd_data.zero ? B_OUT : B_NORM;
                    end
                end
                B_NORM: begin
                    // one halving step of the leading-one search per cycle
                    if (top == 64'd0) begin
                        r_reg  <= r_reg << sh;
                        lz_reg <= lz_reg + sh[5:0];
                    end
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd5) begin
                        state_reg <= B_LOG;
                    end
                end
                B_LOG: begin
                    if (prod[63]) begin
                        m_reg             <= prod[63:32];
                        frac_reg[cnt_reg] <= 1'b1;
                    end else begin
                        m_reg <= prod[62:31];
                    end
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0) begin
                        state_reg <= B_LN;
                    end
                end
                B_LN: begin
                    rad_reg   <= {1'b0, prod[61:23], 16'd0};
                    res_reg   <= '0;
                    bit_reg   <= 56'd1 << 54;
                    cnt_reg   <= 5'd27;
                    state_reg <= B_SQRT;
                end
                B_SQRT: begin
                    if (58'(rad_reg) >= trial) begin
                        rad_reg <= rad_reg - trial[55:0];
                        res_reg <= (res_reg >> 1) + 58'(bit_reg);
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd0) begin
                        state_reg <= B_ANG;
                    end
                end
                B_ANG: begin
                    z_reg     <= prod[60:30];
                    state_reg <= B_Z2;
                end
                B_Z2: begin
                    z2_reg    <= prod[61:30];
                    h_reg     <= gng_pkg::ONE_Q30;
                    cnt_reg   <= '0;
                    state_reg <= B_S1;
                end
                B_S1: begin
                    x_reg     <= prod[61:30];
                    state_reg <= B_S2;
                end
                B_S2: begin
                    q0_reg    <= prod[61:32];
                    state_reg <= B_S3;
                end
                B_S3: begin
                    h_reg   <= gng_pkg::ONE_Q30 - quot;
                    cnt_reg <= cnt_reg + 5'd1;
                    state_reg <= (cnt_reg == 5'd7) ? B_SN : B_S1;
                end
                B_SN: begin
                    sn_reg    <= prod[60:30];
                    state_reg <= B_RT;
                end
                B_RT: begin
                    a_reg     <= prod[58:30];
                    state_reg <= B_SC;
                end
                B_SC: begin
                    sample_reg <= p_reg[31] ? (21'd0 - mag_sat) : mag_sat;
                    state_reg  <= B_OUT;
                end
                default: begin
                    // wait for the output register to free up
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg          <= 1'b1;
                        m_data_reg.sample    <= zero_reg ? 21'sd0 : signed'(sample_reg);
                        m_data_reg.final_res <= last_reg;
                        state_reg            <= B_IDLE;
                    end
                end
            endcase
            if (state_reg == B_NORM && step_reg == 3'd5) begin
                m_reg    <= (top == 64'd0) ? r_reg[62:31] : r_reg[63:32];
                frac_reg <= '0;
                cnt_reg  <= 5'd23;
            end
        end
    end

endmodule

// ===== rtl/core/gng_checker.sv =====
// ----------------------------------------------------------------------------
// gng_checker
// Port-level checks of the Gaussian noise generator, bound to the top level.
// ----------------------------------------------------------------------------
module gng_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input gng_pkg::out_t m_data
);

    // a stalled result beat stays
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result beat changed while stalled");

    // one request at a time: ready drops after each accepted beat
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken back to back");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat shown straight after reset");

endmodule

bind gaussian_noise_generator_top gng_checker u_gng_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks gaussian_noise_generator_top against a bit-exact fixed-point
// Box-Muller predictor. Directed fills, zero scale, zero draw and mid-fill
// scale changes come first, then random fills and noise under random
// back-pressure and random source gaps.
// ----------------------------------------------------------------------------
class noise_scoreboard;
    bit [63:0]     base_seed;
    bit [63:0]     work_seed;
    bit [15:0]     scale;
    gng_pkg::out_t expected_q[$];
    int            errors;
    int            matched;

    function new();
        base_seed = gng_pkg::BASE_SEED_RST;
        work_seed = gng_pkg::WORK_SEED_RST;
        scale     = gng_pkg::SCALE_RST;
        errors    = 0;
        matched   = 0;
    endfunction

    function void configure(logic idx, bit [63:0] value);
        if (idx == gng_pkg::CFG_SEED) base_seed = value;
        else                          scale = value[15:0];
    endfunction

    function bit [63:0] xorshift(inout bit [63:0] s);
        bit [63:0] v;
        v = s;
        v ^= v >> 12;
        v ^= v << 25;
        v ^= v >> 27;
        v = v * gng_pkg::XS_MULT;
        s = v;
        return v;
    endfunction

    // -log2(r * 2^-64) in Q24, r nonzero
    function bit [63:0] neg_log2(bit [63:0] r);
        int        e;
        bit [63:0] m;
        bit [63:0] frac;
        e = 63;
        frac = 0;
        while (!r[e]) e--;
        m = (r << (63 - e)) >> 32;
        for (int i = 23; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32)) begin
                m >>= 1;
                frac[i] = 1'b1;
            end
        end
        return (64'(64 - e) << 24) - frac;
    endfunction

    function bit [63:0] int_sqrt(bit [63:0] v);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function bit [63:0] abs_sine(bit [63:0] z);
        bit [63:0] one;
        bit [63:0] z2;
        bit [63:0] h;
        one = 64'd1 << 30;
        z2 = (z * z) >> 30;
        h = one;
        for (bit [63:0] k = 8; k >= 1; k--)
            h = one - ((z2 * h) >> 30) / ((2 * k) * (2 * k + 1));
        return (z * h) >> 30;
    endfunction

    function void note_request(gng_pkg::in_t req);
        gng_pkg::out_t res;
        bit [63:0]     r1, r2, root, p, q, z, mag;
        res.final_res = req.last;
        res.sample    = '0;
        if (scale != 0) begin
            if (req.first) work_seed = base_seed + 64'd1;
            r1 = xorshift(work_seed);
            r2 = xorshift(work_seed);
            if (r1 == 0) r1 = 1;
            root = int_sqrt(((neg_log2(r1) * 64'(gng_pkg::LN2_Q32)) >> 23) << 16);
            p = r2 >> 32;
            q = p & 64'h7FFF_FFFF;
            if (q > (64'd1 << 30)) q = (64'd1 << 31) - q;
            z = (q * 64'(gng_pkg::HALFPI_Q30)) >> 30;
            mag = (((abs_sine(z) * root) >> 30) * 64'(scale)) >> 24;
            if (p[31]) begin
                if (mag > 64'd1048576) mag = 64'd1048576;
                res.sample = 21'(64'd0 - mag);
            end else begin
                if (mag > 64'd1048575) mag = 64'd1048575;
                res.sample = 21'(mag);
            end
            if (req.last) void'(xorshift(base_seed));
        end
        expected_q.push_back(res);
    endfunction

    function void check_sample(gng_pkg::out_t got);
        gng_pkg::out_t exp_res;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected sample beat %0d final %0b", $time,
                     got.sample, got.final_res);
            errors++;
            return;
        end
        exp_res = expected_q.pop_front();
        if (got.sample !== exp_res.sample) begin
            $display("%0t: sample mismatch expected %0d actual %0d", $time,
                     exp_res.sample, got.sample);
            errors++;
        end
        if (got.final_res !== exp_res.final_res) begin
            $display("%0t: final_res mismatch expected %0b actual %0b", $time,
                     exp_res.final_res, got.final_res);
            errors++;
        end
        matched++;
    endfunction
endclass

module testbench;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 150;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    gng_pkg::in_t  s_data = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    gng_pkg::out_t m_data;
    logic          cfg_wr_en = 1'b0;
    logic          cfg_idx = gng_pkg::CFG_SEED;
    logic [63:0]   cfg_data = '0;

    noise_scoreboard sb = new();
    int  cycles = 0;
    int  requests = 0;
    int  fills = 0;
    int  cfg_writes = 0;
    bit  no_gaps = 1'b0;
    int  stall_mode = 0;

    gaussian_noise_generator_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_wr_en(cfg_wr_en), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // note request beats and check sample beats as they are accepted
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_request(s_data);
            requests++;
        end
        if (aresetn && m_valid && m_ready) sb.check_sample(m_data);
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // sink stalls: change mode now and then, hold ready high in some stretches
    always @(posedge aclk) begin
        if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
        if (stall_mode == 0)      m_ready <= 1'b1;
        else if (stall_mode == 1) m_ready <= ($urandom_range(0, 3) != 0);
        else                      m_ready <= ($urandom_range(0, 19) == 0);
    end

    task automatic send(bit first, bit last);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{first: first, last: last};
        do @(posedge aclk); while (!s_ready);
        if (first) fills++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        // allow the base seed step after a last beat to finish
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, bit [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.configure(idx, value);
        cfg_writes++;
    endtask

    task automatic send_fill(int len);
        for (int i = 0; i < len; i++) send(i == 0, i == len - 1);
    endtask

    initial begin
        bit [63:0] seed_val;
        int        n;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: fill, items without a first flag, single-item fill
        send(1, 0); send(0, 0); send(0, 1); send(1, 1); send(0, 0); send(0, 1);
        settle();

        // zero scale: zeros out, seeds untouched
        write_reg(gng_pkg::CFG_SCALE, 64'd0);
        send(1, 1); send(0, 1); send(1, 0); send(0, 0);
        settle();
        write_reg(gng_pkg::CFG_SCALE, 64'd65535);
        send(0, 0); send(0, 1);
        settle();

        // base seed of all ones wraps the working seed to zero: zero draw
        write_reg(gng_pkg::CFG_SEED, '1);
        send(1, 0); send(0, 1);
        settle();
        write_reg(gng_pkg::CFG_SEED, 64'd0);
        send(1, 1); send(1, 0);
        settle();

        // scale change in the middle of a fill
        write_reg(gng_pkg::CFG_SCALE, 64'd1);
        send(1, 0); send(0, 0);
        settle();
        write_reg(gng_pkg::CFG_SCALE, 64'd4096);
        send(0, 0); send(0, 1);
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            case ($urandom_range(0, 5))
                0: seed_val = '1;
                1: seed_val = 64'd0;
                default: seed_val = {$urandom, $urandom};
            endcase
            write_reg(gng_pkg::CFG_SEED, seed_val);
            case (ph)
                0: write_reg(gng_pkg::CFG_SCALE, 64'd65535);
                1: write_reg(gng_pkg::CFG_SCALE, 64'd0);
                2: write_reg(gng_pkg::CFG_SCALE, 64'd1);
                default: write_reg(gng_pkg::CFG_SCALE, 64'($urandom_range(1, 65535)));
            endcase
            no_gaps = (ph % 3 == 2);
            n = 0;
            while (n < 48) begin
                if ($urandom_range(0, 99) < 85) begin
                    int len;
                    len = $urandom_range(1, 8);
                    send_fill(len);
                    n += len;
                end else begin
                    send($urandom_range(0, 1), $urandom_range(0, 1));
                    n++;
                end
            end
            settle();
        end
        no_gaps = 1'b0;

        $display("covered %0d requests in %0d fills, %0d register writes", requests,
                 fills, cfg_writes);
        $display("%0d samples checked, %0d errors", sb.matched, sb.errors);
        if (sb.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/gng_pkg.sv
rtl/core/gng_front.sv
rtl/core/gng_queue.sv
rtl/core/gng_back.sv
rtl/core/gaussian_noise_generator_top.sv
rtl/core/gng_checker.sv
tb/testbench.sv
